[sv/dll_pkg.sv]
`default_nettype none

package dll_pkg;

  // Pool size and index width (node index field is 8 bits wide)
  localparam int NODES   = 256;
  localparam int IDX_W   = 8;
  localparam int LINK_W  = IDX_W + 1;
  localparam int COUNT_W = 9;

  // A link is a null flag over a node index
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam link_t  LINK_NONE = {1'b1, {IDX_W{1'b0}}};
  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  // Request action codes
  typedef enum logic [2:0] {
    ACT_PREPEND = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  // Internal operation after decode
  typedef enum logic [2:0] {
    OP_NOP,
    OP_HEAD,
    OP_AFTER,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_W1,
    ST_W2,
    ST_FIN
  } state_t;

  // Write port of a link memory
  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  // Result handed from sequencer to the output register
  typedef struct packed {
    link_t  head;
    link_t  tail;
    count_t count;
    logic   under;
  } result_t;

  function automatic link_t to_link(input idx_t i);
    return {1'b0, i};
  endfunction

endpackage

`default_nettype wire

[sv/dll_link_ram.sv]
`default_nettype none

// One link memory: one write port, one registered read port.
// Entries never written read as null (valid bit per entry).
module dll_link_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dll_pkg::link_wr_t wr,
  input  wire logic              re,
  input  wire dll_pkg::idx_t     raddr,
  output dll_pkg::link_t         rdata
);

  dll_pkg::link_t mem [dll_pkg::NODES];
  logic [dll_pkg::NODES-1:0] vld_r;
  dll_pkg::link_t rdata_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // registered read, unwritten entry reads null
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : dll_pkg::LINK_NONE;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/dll_ctrl.sv]
`default_nettype none

// Request sequencer: decodes a request, reads the node links, writes
// neighbour links back and keeps head, tail and length.
module dll_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_action,
  input  wire dll_pkg::idx_t     in_node_index,
  input  wire dll_pkg::idx_t     in_after_node,
  input  wire logic              in_after_present,
  output dll_pkg::link_wr_t      prev_wr,
  output dll_pkg::link_wr_t      next_wr,
  output logic                   rd_en,
  output dll_pkg::idx_t          prev_raddr,
  output dll_pkg::idx_t          next_raddr,
  input  wire dll_pkg::link_t    prev_rd,
  input  wire dll_pkg::link_t    next_rd,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output dll_pkg::result_t       res
);

  dll_pkg::state_t state_r, state_nxt;
  dll_pkg::op_t    op_r, op_nxt;
  dll_pkg::idx_t   node_r, node_nxt;
  dll_pkg::link_t  before_r, before_nxt;
  dll_pkg::link_t  head_r, head_nxt;
  dll_pkg::link_t  tail_r, tail_nxt;
  dll_pkg::count_t count_r, count_nxt;
  logic            under_r, under_nxt;
  dll_pkg::link_t  nx;
  dll_pkg::link_t  node_link;

  assign node_link = dll_pkg::to_link(node_r);

  // state and list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dll_pkg::ST_IDLE;
      op_r    <= dll_pkg::OP_NOP;
      head_r  <= dll_pkg::LINK_NONE;
      tail_r  <= dll_pkg::LINK_NONE;
      count_r <= '0;
      under_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      under_r <= under_nxt;
    end
  end

  // request operands
  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    before_r <= before_nxt;
  end

  // read addresses: remove reads both links of the node,
  // insert-after reads the next link of the predecessor
  assign prev_raddr = node_r;
  assign next_raddr = (op_r == dll_pkg::OP_REMOVE) ? node_r
                                                   : before_r[dll_pkg::IDX_W-1:0];

  // next state and memory writes
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    node_nxt   = node_r;
    before_nxt = before_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    under_nxt  = under_r;
    prev_wr    = '0;
    next_wr    = '0;
    rd_en      = 1'b0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    nx         = dll_pkg::LINK_NONE;

    case (state_r)
      dll_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          node_nxt   = in_node_index;
          before_nxt = dll_pkg::LINK_NONE;
          under_nxt  = 1'b0;
          state_nxt  = dll_pkg::ST_RD;
          case (in_action)
            dll_pkg::ACT_PREPEND: begin
              op_nxt = dll_pkg::OP_HEAD;
            end
            dll_pkg::ACT_APPEND: begin
              if (!tail_r[dll_pkg::IDX_W]) begin
                op_nxt     = dll_pkg::OP_AFTER;
                before_nxt = tail_r;
              end else begin
                op_nxt = dll_pkg::OP_HEAD;
              end
            end
            dll_pkg::ACT_INSERT: begin
              if (in_after_present) begin
                op_nxt     = dll_pkg::OP_AFTER;
                before_nxt = dll_pkg::to_link(in_after_node);
              end else begin
                op_nxt = dll_pkg::OP_HEAD;
              end
            end
            dll_pkg::ACT_REMOVE: begin
              op_nxt = dll_pkg::OP_REMOVE;
            end
            dll_pkg::ACT_CLEAR: begin
              op_nxt    = dll_pkg::OP_CLEAR;
              head_nxt  = dll_pkg::LINK_NONE;
              tail_nxt  = dll_pkg::LINK_NONE;
              count_nxt = '0;
              state_nxt = dll_pkg::ST_FIN;
            end
            default: begin
              op_nxt    = dll_pkg::OP_NOP;
              state_nxt = dll_pkg::ST_FIN;
            end
          endcase
        end
      end

      // issue reads; writes that need no read data
      dll_pkg::ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = dll_pkg::ST_W1;
        case (op_r)
          dll_pkg::OP_HEAD: begin
            prev_wr = '{we: 1'b1, addr: node_r, data: dll_pkg::LINK_NONE};
            next_wr = '{we: 1'b1, addr: node_r, data: head_r};
          end
          dll_pkg::OP_AFTER: begin
            prev_wr = '{we: 1'b1, addr: node_r, data: before_r};
          end
          dll_pkg::OP_REMOVE: begin
          end
          default: begin
            state_nxt = dll_pkg::ST_FIN;
          end
        endcase
      end

      // read data back: relink neighbours, update head, tail, length
      dll_pkg::ST_W1: begin
        state_nxt = dll_pkg::ST_W2;
        case (op_r)
          dll_pkg::OP_HEAD: begin
            if (!head_r[dll_pkg::IDX_W]) begin
              prev_wr = '{we: 1'b1, addr: head_r[dll_pkg::IDX_W-1:0], data: node_link};
            end else begin
              tail_nxt = node_link;
            end
            head_nxt = node_link;
            if (count_r != dll_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
            state_nxt = dll_pkg::ST_FIN;
          end
          dll_pkg::OP_AFTER: begin
            // node equal to its predecessor sees its own fresh next link
            nx = (node_link == before_r) ? node_link : next_rd;
            next_wr = '{we: 1'b1, addr: node_r, data: next_rd};
            if (!nx[dll_pkg::IDX_W]) begin
              prev_wr = '{we: 1'b1, addr: nx[dll_pkg::IDX_W-1:0], data: node_link};
            end else begin
              tail_nxt = node_link;
            end
            if (count_r != dll_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
          end
          dll_pkg::OP_REMOVE: begin
            if (head_r == node_link) head_nxt = next_rd;
            if (tail_r == node_link) tail_nxt = prev_rd;
            if (!prev_rd[dll_pkg::IDX_W]) begin
              next_wr = '{we: 1'b1, addr: prev_rd[dll_pkg::IDX_W-1:0], data: next_rd};
            end
            if (!next_rd[dll_pkg::IDX_W]) begin
              prev_wr = '{we: 1'b1, addr: next_rd[dll_pkg::IDX_W-1:0], data: prev_rd};
            end
            if (count_r == '0) begin
              under_nxt = 1'b1;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
          default: begin
            state_nxt = dll_pkg::ST_FIN;
          end
        endcase
      end

      // final link writes
      dll_pkg::ST_W2: begin
        state_nxt = dll_pkg::ST_FIN;
        case (op_r)
          dll_pkg::OP_AFTER: begin
            next_wr = '{we: 1'b1, addr: before_r[dll_pkg::IDX_W-1:0], data: node_link};
          end
          dll_pkg::OP_REMOVE: begin
            prev_wr = '{we: 1'b1, addr: node_r, data: dll_pkg::LINK_NONE};
            next_wr = '{we: 1'b1, addr: node_r, data: dll_pkg::LINK_NONE};
          end
          default: begin
          end
        endcase
      end

      // hand the result on once the output slot is free
      dll_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = dll_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = dll_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = '{head: head_r, tail: tail_r, count: count_r, under: under_r};

  // checks
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == dll_pkg::ACT_CLEAR) |=>
      (head_r == dll_pkg::LINK_NONE && tail_r == dll_pkg::LINK_NONE && count_r == '0))
    else $error("clear did not empty the list");

  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    under_r |-> (count_r == '0))
    else $error("underflow flagged with non-zero length");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (prev_wr.we || next_wr.we) |->
      (state_r == dll_pkg::ST_RD || state_r == dll_pkg::ST_W1 || state_r == dll_pkg::ST_W2))
    else $error("link write outside the write phase");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("result offered while taking a request");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed");

endmodule

`default_nettype wire

[sv/doubly_linked_list_manager_unit.sv]
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// request  | in        | in_valid / in_ready   | in_action, in_node_index, in_after_node,
//          |           |                       | in_after_present
// result   | out       | out_valid / out_ready | out_head_node, out_head_present,
//          |           |                       | out_tail_node, out_tail_present,
//          |           |                       | out_list_length, out_underflow
//
// One request at a time. Clear and unused codes go straight to the result state;
// head inserts and empty-list appends pass ST_RD and ST_W1; insert-after, other
// appends and remove also ST_W2; one write port per link memory, one write per cycle.
// Reset clears head, tail, length and the per-entry written flags of both link
// memories; no clearing pass. A result waiting in the output register does not
// block the next request; only the one after it waits for out_ready.
module doubly_linked_list_manager_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_node_index,
  input  wire logic [7:0] in_after_node,
  input  wire logic       in_after_present,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_head_node,
  output logic            out_head_present,
  output logic [7:0]      out_tail_node,
  output logic            out_tail_present,
  output logic [8:0]      out_list_length,
  output logic            out_underflow
);

  dll_pkg::link_wr_t prev_wr, next_wr;
  logic              rd_en;
  dll_pkg::idx_t     prev_raddr, next_raddr;
  dll_pkg::link_t    prev_rd, next_rd;
  logic              res_valid, res_ready;
  dll_pkg::result_t  res;

  logic              out_valid_r;
  dll_pkg::result_t  out_r;

  dll_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_node_index    (in_node_index),
    .in_after_node    (in_after_node),
    .in_after_present (in_after_present),
    .prev_wr          (prev_wr),
    .next_wr          (next_wr),
    .rd_en            (rd_en),
    .prev_raddr       (prev_raddr),
    .next_raddr       (next_raddr),
    .prev_rd          (prev_rd),
    .next_rd          (next_rd),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  dll_link_ram u_prev_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (prev_wr),
    .re    (rd_en),
    .raddr (prev_raddr),
    .rdata (prev_rd)
  );

  dll_link_ram u_next_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (next_wr),
    .re    (rd_en),
    .raddr (next_raddr),
    .rdata (next_rd)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  // null pointers show as index zero with the present flag low
  assign out_valid        = out_valid_r;
  assign out_head_present = !out_r.head[dll_pkg::IDX_W];
  assign out_head_node    = out_r.head[dll_pkg::IDX_W] ? '0 : out_r.head[dll_pkg::IDX_W-1:0];
  assign out_tail_present = !out_r.tail[dll_pkg::IDX_W];
  assign out_tail_node    = out_r.tail[dll_pkg::IDX_W] ? '0 : out_r.tail[dll_pkg::IDX_W-1:0];
  assign out_list_length  = out_r.count;
  assign out_underflow    = out_r.under;

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  // Package types and sizes under local names
  typedef dll_pkg::idx_t   idx_t;
  typedef dll_pkg::link_t  link_t;
  typedef dll_pkg::count_t count_t;

  localparam int     NODES     = dll_pkg::NODES;
  localparam int     IDX_W     = dll_pkg::IDX_W;
  localparam link_t  LINK_NONE = dll_pkg::LINK_NONE;
  localparam count_t COUNT_MAX = dll_pkg::COUNT_MAX;

  // Spare action codes: the block must leave the list untouched
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int unsigned REQ_TOTAL   = 1450;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned OVERFILL    = 260;

  typedef struct {
    logic [2:0] act;
    idx_t       node;
    idx_t       after;
    logic       after_given;
  } list_op_t;

  typedef struct {
    idx_t   head_node;
    logic   head_present;
    idx_t   tail_node;
    logic   tail_present;
    count_t list_length;
    logic   underflow;
  } list_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_action = '0;
  logic [7:0] in_node_index = '0;
  logic [7:0] in_after_node = '0;
  logic       in_after_present = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_head_node;
  logic       out_head_present;
  logic [7:0] out_tail_node;
  logic       out_tail_present;
  logic [8:0] out_list_length;
  logic       out_underflow;

  doubly_linked_list_manager_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_node_index    (in_node_index),
    .in_after_node    (in_after_node),
    .in_after_present (in_after_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_head_node    (out_head_node),
    .out_head_present (out_head_present),
    .out_tail_node    (out_tail_node),
    .out_tail_present (out_tail_present),
    .out_list_length  (out_list_length),
    .out_underflow    (out_underflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow list: link memories, ends and length
  link_t  prev_of [NODES];
  link_t  next_of [NODES];
  link_t  first_node = LINK_NONE;
  link_t  last_node = LINK_NONE;
  count_t node_count = '0;

  list_op_t   pending_ops [$];
  list_view_t expected_lists [$];
  list_op_t   on_wire;
  list_view_t want;

  int unsigned issued, sent, received, fails;
  int unsigned underflows_seen, saturated_seen, longest_list;
  int unsigned quiet_cycles;

  // Generator's view of which nodes sit on a well-formed list
  bit          on_list [NODES];
  int unsigned list_size;

  // Link a node in after an anchor, or at the head when the anchor is null
  function automatic void splice_in(link_t anchor, idx_t node);
    link_t nx;
    if (anchor[IDX_W]) begin
      prev_of[node] = LINK_NONE;
      next_of[node] = first_node;
      if (!first_node[IDX_W]) prev_of[first_node[IDX_W-1:0]] = {1'b0, node};
      else last_node = {1'b0, node};
      first_node = {1'b0, node};
    end else begin
      prev_of[node] = anchor;
      next_of[node] = next_of[anchor[IDX_W-1:0]];
      next_of[anchor[IDX_W-1:0]] = {1'b0, node};
      nx = next_of[node];
      if (!nx[IDX_W]) prev_of[nx[IDX_W-1:0]] = {1'b0, node};
      else last_node = {1'b0, node};
    end
    if (node_count != COUNT_MAX) node_count++;
  endfunction

  // Unlink a node and clear its own links; returns 1 on underflow
  function automatic logic splice_out(idx_t node);
    link_t pv, nx;
    pv = prev_of[node];
    nx = next_of[node];
    if (first_node == {1'b0, node}) first_node = nx;
    if (last_node == {1'b0, node}) last_node = pv;
    if (!pv[IDX_W]) next_of[pv[IDX_W-1:0]] = nx;
    if (!nx[IDX_W]) prev_of[nx[IDX_W-1:0]] = pv;
    prev_of[node] = LINK_NONE;
    next_of[node] = LINK_NONE;
    if (node_count == '0) return 1'b1;
    node_count--;
    return 1'b0;
  endfunction

  // Apply one request to the shadow list and return the list it leaves.
  // The pool covers every 8-bit index, so no request falls outside it.
  function automatic list_view_t apply_list_op(list_op_t op);
    list_view_t v;
    logic under;
    under = 1'b0;
    case (op.act)
      dll_pkg::ACT_PREPEND: splice_in(LINK_NONE, op.node);
      dll_pkg::ACT_APPEND:  splice_in(last_node, op.node);
      dll_pkg::ACT_INSERT:
        splice_in(op.after_given ? {1'b0, op.after} : LINK_NONE, op.node);
      dll_pkg::ACT_REMOVE:  under = splice_out(op.node);
      dll_pkg::ACT_CLEAR: begin
        first_node = LINK_NONE;
        last_node  = LINK_NONE;
        node_count = '0;
      end
      default: ;
    endcase
    v.head_present = !first_node[IDX_W];
    v.head_node    = first_node[IDX_W] ? '0 : first_node[IDX_W-1:0];
    v.tail_present = !last_node[IDX_W];
    v.tail_node    = last_node[IDX_W] ? '0 : last_node[IDX_W-1:0];
    v.list_length  = node_count;
    v.underflow    = under;
    return v;
  endfunction

  task automatic queue_op(logic [2:0] act, idx_t node, idx_t after, logic given);
    list_op_t op;
    op.act = act;
    op.node = node;
    op.after = after;
    op.after_given = given;
    pending_ops.push_back(op);
    issued++;
  endtask

  task automatic forget_list();
    foreach (on_list[i]) on_list[i] = 1'b0;
    list_size = 0;
  endtask

  function automatic idx_t pick_free();
    idx_t n;
    do n = idx_t'($urandom_range(NODES - 1, 0)); while (on_list[n]);
    return n;
  endfunction

  function automatic idx_t pick_member();
    idx_t n;
    do n = idx_t'($urandom_range(NODES - 1, 0)); while (!on_list[n]);
    return n;
  endfunction

  // One well-formed request; unused fields carry random values
  task automatic wf_step(int unsigned insert_pct);
    int unsigned roll;
    idx_t n, a;
    roll = $urandom_range(99, 0);
    a = idx_t'($urandom);
    if (list_size != 0 && (list_size == NODES || roll >= insert_pct)) begin
      if (roll >= 98) begin
        queue_op(dll_pkg::ACT_CLEAR, idx_t'($urandom), a, 1'($urandom));
        forget_list();
      end else begin
        n = pick_member();
        queue_op(dll_pkg::ACT_REMOVE, n, a, 1'($urandom));
        on_list[n] = 1'b0;
        list_size--;
      end
    end else begin
      n = pick_free();
      case ($urandom_range(3, 0))
        0: queue_op(dll_pkg::ACT_PREPEND, n, a, 1'($urandom));
        1: queue_op(dll_pkg::ACT_APPEND, n, a, 1'($urandom));
        2: if (list_size != 0) queue_op(dll_pkg::ACT_INSERT, n, pick_member(), 1'b1);
           else queue_op(dll_pkg::ACT_INSERT, n, a, 1'b0);
        default: queue_op(dll_pkg::ACT_INSERT, n, a, 1'b0);
      endcase
      on_list[n] = 1'b1;
      list_size++;
    end
  endtask

  task automatic check_field(string what, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: result %0d %s expected %0d actual %0d",
               $time, received, what, exp_v, got_v);
      fails++;
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = apply_list_op(on_wire);
        expected_lists.push_back(want);
        sent++;
        if (want.underflow) underflows_seen++;
        if (want.list_length == COUNT_MAX) saturated_seen++;
        if (want.list_length > longest_list) longest_list = want.list_length;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 &&
            ((sent >= 300 && sent < 500) || $urandom_range(99, 0) >= 33)) begin
          on_wire = pending_ops.pop_front();
          in_action        <= on_wire.act;
          in_node_index    <= on_wire.node;
          in_after_node    <= on_wire.after;
          in_after_present <= on_wire.after_given;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares against the oldest predicted list
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        received++;
        if (expected_lists.size() == 0) begin
          $display("%0t: result %0d with nothing expected (head %0d tail %0d len %0d)",
                   $time, received, out_head_node, out_tail_node, out_list_length);
          fails++;
        end else begin
          want = expected_lists.pop_front();
          check_field("head_node", want.head_node, out_head_node);
          check_field("head_present", want.head_present, out_head_present);
          check_field("tail_node", want.tail_node, out_tail_node);
          check_field("tail_present", want.tail_present, out_tail_present);
          check_field("list_length", want.list_length, out_list_length);
          check_field("underflow", want.underflow, out_underflow);
        end
      end
      out_ready <= (received >= 300 && received < 500) || $urandom_range(99, 0) >= 33;
    end
  end

  // Cycles in which neither channel moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    foreach (prev_of[i]) begin
      prev_of[i] = LINK_NONE;
      next_of[i] = LINK_NONE;
    end
    forget_list();

    // Directed: empty remove, all insert forms, removes at each position
    queue_op(dll_pkg::ACT_REMOVE, 8'd0, 8'd255, 1'b1);
    queue_op(dll_pkg::ACT_PREPEND, 8'd255, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_APPEND, 8'd0, 8'd255, 1'b1);
    queue_op(dll_pkg::ACT_INSERT, 8'd128, 8'd255, 1'b1);
    queue_op(dll_pkg::ACT_INSERT, 8'd7, 8'd255, 1'b0);
    queue_op(dll_pkg::ACT_INSERT, 8'd200, 8'd0, 1'b1);
    queue_op(dll_pkg::ACT_REMOVE, 8'd7, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_REMOVE, 8'd200, 8'd255, 1'b1);
    queue_op(dll_pkg::ACT_REMOVE, 8'd128, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_REMOVE, 8'd255, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_REMOVE, 8'd0, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_REMOVE, 8'd0, 8'd0, 1'b0);
    // spare codes
    queue_op(ACT_SPARE_FIRST, 8'd255, 8'd255, 1'b1);
    queue_op(ACT_SPARE_FIRST + 3'd1, 8'd0, 8'd0, 1'b0);
    queue_op(ACT_SPARE_LAST, 8'd170, 8'd85, 1'b1);
    // node inserted twice, then clear leaving stale links, then a stale remove
    queue_op(dll_pkg::ACT_APPEND, 8'd3, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_PREPEND, 8'd3, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_CLEAR, 8'd255, 8'd255, 1'b1);
    queue_op(dll_pkg::ACT_REMOVE, 8'd3, 8'd0, 1'b0);
    queue_op(dll_pkg::ACT_CLEAR, 8'd0, 8'd0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // hold off until the directed requests have all come back
    while (pending_ops.size() != 0 || in_valid || expected_lists.size() != 0)
      @(negedge clk);

    // Random: mostly well-formed runs, some noise bursts cleaned up by clear,
    // and once a full list pushed on into length saturation
    while (issued < REQ_TOTAL) begin
      if (issued >= 500 && saturated_seen == 0 && list_size < NODES) begin
        while (list_size < NODES) wf_step(100);
        repeat (OVERFILL)
          queue_op(3'($urandom_range(dll_pkg::ACT_INSERT, dll_pkg::ACT_PREPEND)),
                   idx_t'($urandom), idx_t'($urandom), 1'($urandom));
        queue_op(dll_pkg::ACT_CLEAR, idx_t'($urandom), idx_t'($urandom), 1'($urandom));
        forget_list();
        saturated_seen = 1;
      end else if ($urandom_range(99, 0) < 12) begin
        repeat ($urandom_range(8, 3))
          queue_op(3'($urandom_range(ACT_SPARE_LAST, dll_pkg::ACT_PREPEND)),
                   idx_t'($urandom), idx_t'($urandom), 1'($urandom));
        queue_op(dll_pkg::ACT_CLEAR, idx_t'($urandom), idx_t'($urandom), 1'($urandom));
        forget_list();
      end else begin
        repeat ($urandom_range(60, 10)) wf_step($urandom_range(65, 45));
      end
    end
    // the flag above only steered the generator; count real saturations
    saturated_seen = 0;
    @(negedge clk);
    saturated_seen = 0;

    while (pending_ops.size() != 0 || in_valid || expected_lists.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests, %0d results: %0d underflows, longest list %0d",
             sent, received, underflows_seen, longest_list);
    $display("Mix of directed edge cases, well-formed list runs, noise and an overfill");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
